@@ hdl/kwp_pkg.sv @@
// Package for the KWP2000 frame receiver: parse phases, byte roles,
// status codes, register map and register reset values.
// No dependencies.
package kwp_pkg;

  // Parse phase of the frame being received
  typedef enum logic [2:0] {
    PH_FMT = 3'd0,
    PH_TGT = 3'd1,
    PH_SRC = 3'd2,
    PH_LEN = 3'd3,
    PH_PAY = 3'd4,
    PH_CS  = 3'd5
  } phase_t;

  // Byte roles
  localparam logic [2:0] ROLE_FMT  = 3'd0;
  localparam logic [2:0] ROLE_TGT  = 3'd1;
  localparam logic [2:0] ROLE_SRC  = 3'd2;
  localparam logic [2:0] ROLE_LEN  = 3'd3;
  localparam logic [2:0] ROLE_SID  = 3'd4;
  localparam logic [2:0] ROLE_DATA = 3'd5;
  localparam logic [2:0] ROLE_CS   = 3'd6;
  localparam logic [2:0] ROLE_DISC = 3'd7;

  // Frame status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FAULT  = 3'd1;
  localparam logic [2:0] ST_CS_ERR = 3'd2;
  localparam logic [2:0] ST_NEG    = 3'd3;
  localparam logic [2:0] ST_NOSUP  = 3'd4;

  // Format byte fields
  localparam logic [7:0] FMT_ADDR_MASK = 8'hC0;
  localparam logic [7:0] FMT_LEN_MASK  = 8'h3F;

  // Register map: byte address = 4 * index
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_NEG_SID = 3'd0;
  localparam logic [2:0] REG_CODE_A  = 3'd1;
  localparam logic [2:0] REG_CODE_B  = 3'd2;
  localparam logic [2:0] REG_CODE_C  = 3'd3;
  localparam logic [2:0] REG_CODE_D  = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_NEG_SID = 8'h7F;
  localparam logic [7:0] RST_CODE_A  = 8'h11;
  localparam logic [7:0] RST_CODE_B  = 8'h12;
  localparam logic [7:0] RST_CODE_C  = 8'h31;
  localparam logic [7:0] RST_CODE_D  = 8'h80;

endpackage

@@ hdl/kwp_if.sv @@
// Valid/ready channel interfaces for the KWP2000 frame receiver:
// received bytes in, tagged bytes out. No dependencies.
interface kwp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_fault;

  modport source (output valid, rx_byte, rx_fault, input ready);
  modport sink   (input valid, rx_byte, rx_fault, output ready);
endinterface

interface kwp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [2:0] byte_role;
  logic [7:0] data_index;
  logic       frame_done;
  logic [2:0] status;
  logic [2:0] header_kind;
  logic [7:0] payload_length;
  logic [7:0] target_addr;
  logic [7:0] source_addr;
  logic [7:0] svc_id;

  modport source (output valid, byte_value, byte_role, data_index, frame_done,
                  status, header_kind, payload_length, target_addr,
                  source_addr, svc_id, input ready);
  modport sink   (input valid, byte_value, byte_role, data_index, frame_done,
                  status, header_kind, payload_length, target_addr,
                  source_addr, svc_id, output ready);
endinterface

@@ hdl/kwp2000_frame_receiver.sv @@
// KWP2000 frame receiver top level: frame parser state, result register
// and APB register file. Depends on kwp_pkg and kwp_if.
//
// Usage:
//  - in_ch carries one received byte per request (rx_byte, rx_fault).
//  - out_ch returns one request per input byte: the byte echoed, its role
//    in the frame, the data index and the frame header seen so far. The
//    checksum byte (or a faulted byte) closes the frame with frame_done
//    and a status; the parser then waits for a new format byte.
//  - A byte that is accepted shows on out_ch from the next cycle. Throughput
//    is one byte per cycle while out_ch does not stall; the frame state
//    update and the result are computed in the accept cycle and the only
//    stored stage is the output register.
//  - in_ch.ready is high while the output register is empty or is being
//    taken, so a stalled receiver holds its result and back-pressures
//    in the same cycle.
//  - Reset (rst_n low, synchronous) empties the output register, returns
//    the parser to expecting a format byte and loads the register defaults.
//  - Registers (APB, byte address 4*i): negative SID, four unsupported
//    response codes. Write them only while no frame is in progress.
module kwp2000_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  kwp_in_if.sink                        in_ch,
  kwp_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kwp_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Configuration registers
  logic [7:0] neg_sid_r, code_a_r, code_b_r, code_c_r, code_d_r;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign reg_idx = paddr[kwp_pkg::CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_sid_r <= kwp_pkg::RST_NEG_SID;
      code_a_r  <= kwp_pkg::RST_CODE_A;
      code_b_r  <= kwp_pkg::RST_CODE_B;
      code_c_r  <= kwp_pkg::RST_CODE_C;
      code_d_r  <= kwp_pkg::RST_CODE_D;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        kwp_pkg::REG_NEG_SID: neg_sid_r <= pwdata[7:0];
        kwp_pkg::REG_CODE_A:  code_a_r  <= pwdata[7:0];
        kwp_pkg::REG_CODE_B:  code_b_r  <= pwdata[7:0];
        kwp_pkg::REG_CODE_C:  code_c_r  <= pwdata[7:0];
        kwp_pkg::REG_CODE_D:  code_d_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      kwp_pkg::REG_NEG_SID: prdata = {24'd0, neg_sid_r};
      kwp_pkg::REG_CODE_A:  prdata = {24'd0, code_a_r};
      kwp_pkg::REG_CODE_B:  prdata = {24'd0, code_b_r};
      kwp_pkg::REG_CODE_C:  prdata = {24'd0, code_c_r};
      kwp_pkg::REG_CODE_D:  prdata = {24'd0, code_d_r};
      default:              prdata = 32'd0;
    endcase
  end

  // Frame state
  kwp_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] tgt_r, tgt_nxt, src_r, src_nxt, len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt, sum_r, sum_nxt, sid_r, sid_nxt;
  logic [7:0] resp_r, resp_nxt;

  // Output register
  logic       out_valid_r;
  logic [7:0] val_r, didx_r, plen_r, taddr_r, saddr_r, sidout_r;
  logic [2:0] role_r, status_r, hkind_r;
  logic       done_r;

  logic       accept;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Parser: updated frame fields, result of this byte, then frame clear
  logic [1:0] kind_u;
  logic [7:0] tgt_u, src_u, len_u, cnt_u, sum_u, sid_u, resp_u, sum_add;
  logic [2:0] role_c, status_c;
  logic [7:0] didx_c;
  logic       done_c, addr_c, lenb_c, unsup_c;
  kwp_pkg::phase_t phase_u;

  always_comb begin
    kind_u   = kind_r;
    tgt_u    = tgt_r;
    src_u    = src_r;
    len_u    = len_r;
    cnt_u    = cnt_r;
    sid_u    = sid_r;
    resp_u   = resp_r;
    phase_u  = phase_r;
    sum_add  = sum_r + in_ch.rx_byte;
    sum_u    = sum_r;
    role_c   = kwp_pkg::ROLE_DISC;
    status_c = kwp_pkg::ST_OK;
    didx_c   = 8'd0;
    done_c   = 1'b0;
    addr_c   = (in_ch.rx_byte & kwp_pkg::FMT_ADDR_MASK) != 8'd0;
    lenb_c   = (in_ch.rx_byte & kwp_pkg::FMT_LEN_MASK) == 8'd0;
    unsup_c  = (resp_r == code_a_r) || (resp_r == code_b_r) ||
               (resp_r == code_c_r) || (resp_r == code_d_r);

    if (in_ch.rx_fault) begin
      done_c   = 1'b1;
      status_c = kwp_pkg::ST_FAULT;
    end else begin
      unique case (phase_r)
        kwp_pkg::PH_TGT: begin
          role_c  = kwp_pkg::ROLE_TGT;
          tgt_u   = in_ch.rx_byte;
          sum_u   = sum_add;
          phase_u = kwp_pkg::PH_SRC;
        end
        kwp_pkg::PH_SRC: begin
          role_c  = kwp_pkg::ROLE_SRC;
          src_u   = in_ch.rx_byte;
          sum_u   = sum_add;
          if (kind_r[0])
            phase_u = kwp_pkg::PH_LEN;
          else
            phase_u = (len_r != 8'd0) ? kwp_pkg::PH_PAY : kwp_pkg::PH_CS;
        end
        kwp_pkg::PH_LEN: begin
          role_c  = kwp_pkg::ROLE_LEN;
          len_u   = in_ch.rx_byte;
          sum_u   = sum_add;
          phase_u = (in_ch.rx_byte != 8'd0) ? kwp_pkg::PH_PAY : kwp_pkg::PH_CS;
        end
        kwp_pkg::PH_PAY: begin
          if (cnt_r == 8'd0) begin
            role_c = kwp_pkg::ROLE_SID;
            sid_u  = in_ch.rx_byte;
          end else begin
            role_c = kwp_pkg::ROLE_DATA;
            didx_c = cnt_r - 8'd1;
            if (cnt_r == 8'd2)
              resp_u = in_ch.rx_byte;
          end
          sum_u = sum_add;
          cnt_u = cnt_r + 8'd1;
          if (cnt_u >= len_r)
            phase_u = kwp_pkg::PH_CS;
        end
        kwp_pkg::PH_CS: begin
          role_c = kwp_pkg::ROLE_CS;
          done_c = 1'b1;
          if (in_ch.rx_byte != sum_r)
            status_c = kwp_pkg::ST_CS_ERR;
          else if (len_r >= 8'd1 && sid_r == neg_sid_r)
            status_c = (len_r >= 8'd3 && unsup_c) ? kwp_pkg::ST_NOSUP : kwp_pkg::ST_NEG;
        end
        default: begin
          // format byte starts a fresh frame
          role_c  = kwp_pkg::ROLE_FMT;
          kind_u  = {addr_c, lenb_c};
          tgt_u   = 8'd0;
          src_u   = 8'd0;
          len_u   = in_ch.rx_byte & kwp_pkg::FMT_LEN_MASK;
          cnt_u   = 8'd0;
          sid_u   = 8'd0;
          resp_u  = 8'd0;
          sum_u   = in_ch.rx_byte;
          if (addr_c)
            phase_u = kwp_pkg::PH_TGT;
          else
            phase_u = lenb_c ? kwp_pkg::PH_LEN : kwp_pkg::PH_PAY;
        end
      endcase
    end

    // Frame ends: back to reset values after reporting
    if (done_c) begin
      phase_nxt = kwp_pkg::PH_FMT;
      kind_nxt  = 2'd0;
      tgt_nxt   = 8'd0;
      src_nxt   = 8'd0;
      len_nxt   = 8'd0;
      cnt_nxt   = 8'd0;
      sum_nxt   = 8'd0;
      sid_nxt   = 8'd0;
      resp_nxt  = 8'd0;
    end else begin
      phase_nxt = phase_u;
      kind_nxt  = kind_u;
      tgt_nxt   = tgt_u;
      src_nxt   = src_u;
      len_nxt   = len_u;
      cnt_nxt   = cnt_u;
      sum_nxt   = sum_u;
      sid_nxt   = sid_u;
      resp_nxt  = resp_u;
    end
  end

  // Frame state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kwp_pkg::PH_FMT;
      kind_r  <= 2'd0;
      tgt_r   <= 8'd0;
      src_r   <= 8'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      sum_r   <= 8'd0;
      sid_r   <= 8'd0;
      resp_r  <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      tgt_r   <= tgt_nxt;
      src_r   <= src_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      sid_r   <= sid_nxt;
      resp_r  <= resp_nxt;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (accept)
      out_valid_r <= 1'b1;
    else if (out_ch.ready)
      out_valid_r <= 1'b0;
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r    <= in_ch.rx_byte;
      role_r   <= role_c;
      didx_r   <= didx_c;
      done_r   <= done_c;
      status_r <= status_c;
      hkind_r  <= {1'b0, kind_u} + 3'd1;
      plen_r   <= len_u;
      taddr_r  <= tgt_u;
      saddr_r  <= src_u;
      sidout_r <= sid_u;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_value     = val_r;
  assign out_ch.byte_role      = role_r;
  assign out_ch.data_index     = didx_r;
  assign out_ch.frame_done     = done_r;
  assign out_ch.status         = status_r;
  assign out_ch.header_kind    = hkind_r;
  assign out_ch.payload_length = plen_r;
  assign out_ch.target_addr    = taddr_r;
  assign out_ch.source_addr    = saddr_r;
  assign out_ch.svc_id         = sidout_r;

endmodule

@@ hdl/kwp_checker.sv @@
// Port-level checks for the KWP2000 frame receiver, bound to the top level.
// Depends on kwp_pkg and kwp2000_frame_receiver.
module kwp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] byte_role,
  input logic       frame_done,
  input logic [2:0] status,
  input logic [7:0] byte_value
);

  // An accepted byte always produces a result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte gave no result");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(byte_role))
    else $error("stalled result changed");

  // Frames close only on a checksum or a discarded byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |->
      byte_role == kwp_pkg::ROLE_CS || byte_role == kwp_pkg::ROLE_DISC)
    else $error("frame closed on wrong role");

  // Status is reported only when a frame closes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_done |-> status == kwp_pkg::ST_OK)
    else $error("status without frame end");

  // A discarded byte always aborts with a receive fault
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_role == kwp_pkg::ROLE_DISC |->
      frame_done && status == kwp_pkg::ST_FAULT)
    else $error("discarded byte without fault abort");

endmodule

bind kwp2000_frame_receiver kwp_checker u_kwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .byte_role  (out_ch.byte_role),
  .frame_done (out_ch.frame_done),
  .status     (out_ch.status),
  .byte_value (out_ch.byte_value)
);
